>>> hw/rtl/octree_ambient_light_sampler_unit_assert.svh
// assertion macros used by the checker file
`ifndef OCTREE_AMBIENT_LIGHT_SAMPLER_UNIT_ASSERT_SVH
`define OCTREE_AMBIENT_LIGHT_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define OALS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/oals_pkg.sv
package oals_pkg;

    localparam int NODE_ENTRIES_DEF   = 4096;
    localparam int SAMPLE_ENTRIES_DEF = 4096;
    localparam int MAX_LEVELS_DEF     = 32;

    localparam int CHILDREN     = 8;
    localparam int SAMPLE_BYTES = 18;
    localparam int CH_COUNT     = 6;
    localparam int COLORS       = 3;

    localparam logic [1:0] OP_NODE_WR   = 2'd0;
    localparam logic [1:0] OP_SAMPLE_WR = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic REG_NODE_COUNT   = 1'b0;
    localparam logic REG_SAMPLE_COUNT = 1'b1;

    localparam logic signed [17:0] CUBE_MIN = -18'sd32768;
    localparam logic signed [17:0] CUBE_MAX = 18'sd32768;
    localparam logic [16:0]        FRAC_ONE = 17'h10000;
    localparam logic [2:0]         LAST_CH  = 3'd5;

    typedef struct packed {
        logic [7:0][14:0] cidx;
        logic [7:0]       cvalid;
        logic [2:0][23:0] pt;
        logic [2:0][17:0] cmin;
        logic [16:0]      csize;
    } walk_res_t;

    typedef enum logic [2:0] {
        T_IDLE, T_ISSUE, T_WAIT, T_KIDS, T_DONE
    } tree_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_FRAC, S_WXY, S_WXYZ, S_ACC, S_OUT
    } shade_state_t;

endpackage

>>> hw/rtl/oals_tree.sv
module oals_tree import oals_pkg::*; #(
    parameter int NODE_ENTRIES = NODE_ENTRIES_DEF,
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [14:0] wr_index,
    input  logic [2:0]  wr_slot,
    input  logic [15:0] wr_value,
    input  logic        start,
    input  logic [23:0] pt_x,
    input  logic [23:0] pt_y,
    input  logic [23:0] pt_z,
    input  logic [15:0] ncount,
    input  logic [15:0] scount,
    output logic        done,
    output walk_res_t   res
);

    localparam int NA = $clog2(NODE_ENTRIES * CHILDREN);
    localparam int LW = $clog2(MAX_LEVELS + 1);

    logic [15:0] node_mem [NODE_ENTRIES * CHILDREN];
    logic [15:0] rdata_reg;
    logic        rd_en;
    logic [NA-1:0] rd_addr;

    tree_state_t state_reg, state_next;
    logic signed [23:0] pt_reg [3], pt_next [3];
    logic signed [17:0] mn_reg [3], mn_next [3];
    logic signed [17:0] mx_reg [3], mx_next [3];
    logic signed [17:0] mid [3];
    logic signed [18:0] msum [3];
    logic [14:0]   node_reg, node_next;
    logic [LW-1:0] level_reg, level_next;
    logic [2:0]    oct_reg, oct_next, oct;
    logic [15:0]   word_reg, word_next;
    logic [15:0]   kid_reg [8], kid_next [8];
    logic [3:0]    kcnt_reg, kcnt_next;
    logic          hit_reg, hit_next;
    logic          all_leaf;
    logic [18:0]   size0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[NA'({wr_index, wr_slot})] <= wr_value;
        end
        if (rd_en) begin
            rdata_reg <= node_mem[rd_addr];
        end
    end

    // octant from the cell midpoint, truncated toward zero
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            msum[a] = 19'(mn_reg[a]) + 19'(mx_reg[a]);
            mid[a]  = 18'((msum[a] + 19'(msum[a][18])) >>> 1);
            oct[a]  = 26'(pt_reg[a]) >= $signed({mid[a], 8'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            pt_reg[a] <= pt_next[a];
            mn_reg[a] <= mn_next[a];
            mx_reg[a] <= mx_next[a];
        end
        for (int c = 0; c < CHILDREN; c++) begin
            kid_reg[c] <= kid_next[c];
        end
        node_reg  <= node_next;
        level_reg <= level_next;
        oct_reg   <= oct_next;
        word_reg  <= word_next;
        kcnt_reg  <= kcnt_next;
        hit_reg   <= hit_next;
    end

    always_comb begin
        state_next = state_reg;
        for (int a = 0; a < 3; a++) begin
            pt_next[a] = pt_reg[a];
            mn_next[a] = mn_reg[a];
            mx_next[a] = mx_reg[a];
        end
        for (int c = 0; c < CHILDREN; c++) begin
            kid_next[c] = kid_reg[c];
        end
        node_next  = node_reg;
        level_next = level_reg;
        oct_next   = oct_reg;
        word_next  = word_reg;
        kcnt_next  = kcnt_reg;
        hit_next   = hit_reg;
        rd_en      = 1'b0;
        rd_addr    = NA'({node_reg, oct});
        done       = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (start) begin
                    pt_next[0] = pt_x;
                    pt_next[1] = pt_y;
                    pt_next[2] = pt_z;
                    for (int a = 0; a < 3; a++) begin
                        mn_next[a] = CUBE_MIN;
                        mx_next[a] = CUBE_MAX;
                    end
                    node_next  = '0;
                    level_next = '0;
                    hit_next   = 1'b0;
                    if (ncount == '0 || scount == '0) begin
                        state_next = T_DONE;
                    end else begin
                        state_next = T_ISSUE;
                    end
                end
            end
            T_ISSUE: begin
                if ({1'b0, node_reg} >= ncount) begin
                    state_next = T_DONE;
                end else begin
                    rd_en      = 1'b1;
                    oct_next   = oct;
                    state_next = T_WAIT;
                end
            end
            T_WAIT: begin
                if (rdata_reg[15]) begin
                    word_next  = rdata_reg;
                    kcnt_next  = '0;
                    state_next = T_KIDS;
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        if (oct_reg[a]) begin
                            mn_next[a] = mid[a];
                        end else begin
                            mx_next[a] = mid[a];
                        end
                    end
                    node_next  = rdata_reg[14:0];
                    level_next = level_reg + 1'b1;
                    if (level_reg + 1'b1 == LW'(MAX_LEVELS)) begin
                        state_next = T_DONE;
                    end else begin
                        state_next = T_ISSUE;
                    end
                end
            end
            T_KIDS: begin
                // one child read issued per cycle, the previous one captured
                rd_addr = NA'({node_reg, kcnt_reg[2:0]});
                rd_en   = !kcnt_reg[3];
                if (kcnt_reg != '0) begin
                    kid_next[kcnt_reg[2:0] - 3'd1] = rdata_reg;
                end
                kcnt_next = kcnt_reg + 1'b1;
                if (kcnt_reg[3]) begin
                    hit_next   = 1'b1;
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                done       = 1'b1;
                state_next = T_IDLE;
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb begin
        all_leaf = 1'b1;
        for (int c = 0; c < CHILDREN; c++) begin
            all_leaf = all_leaf & kid_reg[c][15];
        end
        for (int c = 0; c < CHILDREN; c++) begin
            res.cidx[c]   = all_leaf ? kid_reg[c][14:0] : word_reg[14:0];
            res.cvalid[c] = hit_reg && ({1'b0, res.cidx[c]} < scount);
        end
        for (int a = 0; a < 3; a++) begin
            res.pt[a]   = pt_reg[a];
            res.cmin[a] = mn_reg[a];
        end
        size0     = 19'(mx_reg[0]) - 19'(mn_reg[0]);
        res.csize = size0[16:0];
    end

endmodule

>>> hw/rtl/oals_shade.sv
module oals_shade import oals_pkg::*; #(
    parameter int SAMPLE_ENTRIES = SAMPLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [14:0] wr_index,
    input  logic [4:0]  wr_slot,
    input  logic [7:0]  wr_byte,
    input  logic        start,
    input  walk_res_t   res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam int SA = $clog2(SAMPLE_ENTRIES * SAMPLE_BYTES);

    function automatic logic [19:0] byte_addr(input logic [14:0] idx, input logic [4:0] slot);
        logic [19:0] x;
        x = {5'b0, idx};
        return (x << 4) + (x << 1) + {15'b0, slot};
    endfunction

    logic [7:0] sample_mem [SAMPLE_ENTRIES * SAMPLE_BYTES];
    logic [7:0] rdata_reg;
    logic       rd_en;
    logic [SA-1:0] rd_addr;

    shade_state_t state_reg, state_next;
    walk_res_t    res_reg, res_next;
    logic [16:0]  f_reg [3], f_next [3];
    logic [32:0]  wxy_reg [4], wxy_next [4];
    logic [48:0]  w_reg [8], w_next [8];
    logic [3:0]   cnt_reg, cnt_next;
    logic [1:0]   col_reg, col_next;
    logic [2:0]   ch_reg, ch_next;
    logic [56:0]  acc_reg, acc_next;
    logic [7:0]   rgb_reg [3], rgb_next [3];
    logic         m_valid_reg, m_valid_next;
    logic [31:0]  m_data_reg, m_data_next;
    logic         m_last_reg, m_last_next;
    logic         load;

    logic [4:0]  kpos;
    logic signed [26:0] d [3];
    logic [40:0] f_full [3];
    logic [16:0] f_calc [3];
    logic [16:0] fsel0, fsel1, fsel2;
    logic [4:0]  slot;
    logic [2:0]  prev;
    logic [56:0] term, sum;
    logic [57:0] rounded;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_mem[SA'(byte_addr(wr_index, wr_slot))] <= wr_byte;
        end
        if (rd_en) begin
            rdata_reg <= sample_mem[rd_addr];
        end
    end

    // cell size is a power of two or zero
    always_comb begin
        kpos = '0;
        for (int i = 0; i < 17; i++) begin
            if (res_reg.csize[i]) begin
                kpos = 5'(i);
            end
        end
        for (int a = 0; a < 3; a++) begin
            d[a] = 27'($signed(res_reg.pt[a])) - 27'($signed({res_reg.cmin[a], 8'b0}));
            f_full[a] = {d[a][24:0], 16'b0} >> (6'(kpos) + 6'd8);
            if (d[a] <= 0 || res_reg.csize == '0) begin
                f_calc[a] = '0;
            end else if (f_full[a] > 41'(FRAC_ONE)) begin
                f_calc[a] = FRAC_ONE;
            end else begin
                f_calc[a] = f_full[a][16:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        for (int a = 0; a < 3; a++) begin
            f_reg[a]   <= f_next[a];
            rgb_reg[a] <= rgb_next[a];
        end
        for (int i = 0; i < 4; i++) begin
            wxy_reg[i] <= wxy_next[i];
        end
        for (int i = 0; i < CHILDREN; i++) begin
            w_reg[i] <= w_next[i];
        end
        cnt_reg    <= cnt_next;
        col_reg    <= col_next;
        ch_reg     <= ch_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        for (int a = 0; a < 3; a++) begin
            f_next[a]   = f_reg[a];
            rgb_next[a] = rgb_reg[a];
        end
        for (int i = 0; i < 4; i++) begin
            wxy_next[i] = wxy_reg[i];
        end
        for (int i = 0; i < CHILDREN; i++) begin
            w_next[i] = w_reg[i];
        end
        cnt_next = cnt_reg;
        col_next = col_reg;
        ch_next  = ch_reg;
        acc_next = acc_reg;
        load     = 1'b0;

        fsel0   = cnt_reg[0] ? f_reg[0] : FRAC_ONE - f_reg[0];
        fsel1   = cnt_reg[1] ? f_reg[1] : FRAC_ONE - f_reg[1];
        fsel2   = cnt_reg[2] ? f_reg[2] : FRAC_ONE - f_reg[2];
        slot    = 5'({ch_reg, 1'b0}) + 5'(ch_reg) + 5'(col_reg);
        rd_en   = 1'b0;
        rd_addr = SA'(byte_addr(res_reg.cidx[cnt_reg[2:0]], slot));
        prev    = cnt_reg[2:0] - 3'd1;
        term    = (cnt_reg != '0 && res_reg.cvalid[prev]) ?
                  57'(rdata_reg) * 57'(w_reg[prev]) : '0;
        sum     = (cnt_reg == '0 ? '0 : acc_reg) + term;
        rounded = 58'(sum) + (58'd1 << 47);

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    res_next   = res;
                    state_next = S_FRAC;
                end
            end
            S_FRAC: begin
                for (int a = 0; a < 3; a++) begin
                    f_next[a] = f_calc[a];
                end
                cnt_next   = '0;
                state_next = S_WXY;
            end
            S_WXY: begin
                wxy_next[cnt_reg[1:0]] = 33'(34'(fsel0) * 34'(fsel1));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3) begin
                    cnt_next   = '0;
                    state_next = S_WXYZ;
                end
            end
            S_WXYZ: begin
                w_next[cnt_reg[2:0]] = 49'(50'(wxy_reg[cnt_reg[1:0]]) * 50'(fsel2));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[2:0] == 3'd7) begin
                    cnt_next   = '0;
                    col_next   = '0;
                    ch_next    = '0;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                rd_en    = !cnt_reg[3];
                acc_next = sum;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[3]) begin
                    rgb_next[col_reg] = (rounded[57:48] > 10'd255) ? 8'd255 : rounded[55:48];
                    cnt_next = '0;
                    if (col_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    load = 1'b1;
                    if (ch_reg == LAST_CH) begin
                        state_next = S_IDLE;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        col_next   = '0;
                        state_next = S_ACC;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = load | (m_valid_reg & !m_tready);
        m_data_next  = load ? {5'b0, rgb_reg[2], rgb_reg[1], rgb_reg[0], ch_reg} : m_data_reg;
        m_last_next  = load ? (ch_reg == LAST_CH) : m_last_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hw/rtl/octree_ambient_light_sampler_unit.sv
// octree ambient light sampler
// s_ channel: one item per handshake; s_tuser holds the operation (node child
// write, sample byte write or point query). writes land in the node or sample
// memory at the accepting edge and produce nothing. a query produces six
// items on the m_ channel, one per ambient direction, tlast on the sixth.
// the apb port sets node_count (0x0) and sample_count (0x4); write it only
// while no query is in flight.
// a query walks the octree one level at a time (node memory read, then the
// octant step), up to MAX_LEVELS levels, then reads the eight children of the
// leaf node. shading then works out the fractions and corner weights and
// accumulates each colour byte through the one sample memory port, 18 bytes
// in all, then loads one output item per channel.
// write items leave s_tready high.
// s_tready stays low from a query until its last item is taken; a stall on
// m_tready holds the output register and pauses the shading sequencer.
// reset returns both sequencers to idle and clears the count registers;
// memory contents are not cleared.
module octree_ambient_light_sampler_unit import oals_pkg::*; #(
    parameter int NODE_ENTRIES   = NODE_ENTRIES_DEF,
    parameter int SAMPLE_ENTRIES = SAMPLE_ENTRIES_DEF,
    parameter int MAX_LEVELS     = MAX_LEVELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[14:0], slot[19:15], write_value[35:20], point_x[59:36],
    // point_y[83:60], point_z[107:84]
    input  logic [111:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // channel[2:0], red[10:3], green[18:11], blue[26:19]
    output logic [31:0]  m_tdata,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [15:0] NODE_LIM   = 16'(NODE_ENTRIES);
    localparam logic [15:0] SAMPLE_LIM = 16'(SAMPLE_ENTRIES);

    logic        busy_reg, busy_next;
    logic [12:0] node_count_reg, node_count_next;
    logic [12:0] sample_count_reg, sample_count_next;
    logic        s_acc, cfg_wr;
    logic [14:0] entry_index;
    logic [4:0]  slot;
    logic [15:0] write_value;
    logic [15:0] ncount, scount;
    logic        node_wr, sample_wr, query;
    logic        walk_done;
    walk_res_t   walk_res;

    assign entry_index = s_tdata[14:0];
    assign slot        = s_tdata[19:15];
    assign write_value = s_tdata[35:20];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = {19'b0, (paddr[2] == REG_SAMPLE_COUNT) ? sample_count_reg : node_count_reg};

    always_comb begin
        node_count_next   = node_count_reg;
        sample_count_next = sample_count_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                node_count_next = pwdata[12:0];
            end else begin
                sample_count_next = pwdata[12:0];
            end
        end
    end

    assign ncount = ({3'b0, node_count_reg} > NODE_LIM) ? NODE_LIM : {3'b0, node_count_reg};
    assign scount = ({3'b0, sample_count_reg} > SAMPLE_LIM) ? SAMPLE_LIM : {3'b0, sample_count_reg};

    assign s_tready  = !busy_reg;
    assign s_acc     = s_tvalid & s_tready;
    assign node_wr   = s_acc && s_tuser == OP_NODE_WR &&
                       {1'b0, entry_index} < NODE_LIM && slot[4:3] == 2'b0;
    assign sample_wr = s_acc && s_tuser == OP_SAMPLE_WR &&
                       {1'b0, entry_index} < SAMPLE_LIM && slot < 5'(SAMPLE_BYTES);
    assign query     = s_acc && s_tuser == OP_QUERY;

    always_comb begin
        busy_next = busy_reg;
        if (query) begin
            busy_next = 1'b1;
        end else if (m_tvalid && m_tready && m_tlast) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            node_count_reg   <= '0;
            sample_count_reg <= '0;
        end else begin
            busy_reg         <= busy_next;
            node_count_reg   <= node_count_next;
            sample_count_reg <= sample_count_next;
        end
    end

    oals_tree #(
        .NODE_ENTRIES (NODE_ENTRIES),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_tree (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (node_wr),
        .wr_index (entry_index),
        .wr_slot  (slot[2:0]),
        .wr_value (write_value),
        .start    (query),
        .pt_x     (s_tdata[59:36]),
        .pt_y     (s_tdata[83:60]),
        .pt_z     (s_tdata[107:84]),
        .ncount   (ncount),
        .scount   (scount),
        .done     (walk_done),
        .res      (walk_res)
    );

    oals_shade #(
        .SAMPLE_ENTRIES (SAMPLE_ENTRIES)
    ) u_shade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (sample_wr),
        .wr_index (entry_index),
        .wr_slot  (slot),
        .wr_byte  (write_value[7:0]),
        .start    (walk_done),
        .res      (walk_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/oals_checker.sv
`include "octree_ambient_light_sampler_unit_assert.svh"

module oals_checker import oals_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    `OALS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")

    `OALS_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == OP_QUERY, !s_tready, "input taken while a query is in flight")

    `OALS_ASSERT_IMPLY(a_idle_empty, aclk, aresetn, s_tready, !m_tvalid, "result item pending while input is open")

    `OALS_ASSERT_IMPLY(a_last_ch, aclk, aresetn, m_tvalid, m_tlast == (m_tdata[2:0] == LAST_CH), "tlast not on the sixth channel")

endmodule

bind octree_ambient_light_sampler_unit oals_checker u_oals_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import oals_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         LOADED      = 6;     // nodes and samples kept fully written
    localparam int         STALL_LIMIT = 3000;
    localparam int         SETTLE      = 20;
    localparam logic [2:0] ADDR_NODES   = {REG_NODE_COUNT, 2'b00};
    localparam logic [2:0] ADDR_SAMPLES = {REG_SAMPLE_COUNT, 2'b00};

    typedef struct {
        logic [1:0]         op;
        logic [14:0]        idx;
        logic [4:0]         slot;
        logic [15:0]        val;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
    } req_t;

    typedef struct {
        logic [2:0] channel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } shade_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    octree_ambient_light_sampler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mirror of the block
    logic [15:0] node_mem [0:NODE_ENTRIES_DEF*CHILDREN-1];
    logic [7:0]  sample_mem [0:SAMPLE_ENTRIES_DEF*SAMPLE_BYTES-1];
    logic [12:0] node_count_reg = '0;
    logic [12:0] sample_count_reg = '0;

    req_t   pending_q[$];
    shade_t shade_q[$];
    int     fail_count = 0;
    int     query_count = 0;
    int     write_count = 0;
    int     result_count = 0;

    function automatic longint unsigned axis_frac(longint p, int lo, int size);
        longint          d;
        longint unsigned f;
        d = p - longint'(lo) * 256;
        if (d <= 0 || size <= 0) return 0;
        f = longint'(d << 16) / (longint'(size) * 256);
        return (f > 65536) ? 65536 : f;
    endfunction

    task automatic shade_point(input req_t it);
        longint          p[3];
        int              mn[3], mx[3], cmin[3], mid[3];
        int              csize, ncount, scount, node, oct, s;
        logic [15:0]     word, w16;
        logic            all_leaf;
        logic [7:0]      corner[8][18];
        longint unsigned f[3], wt, sum, r;
        logic [7:0]      rgb[3];
        shade_t          res;
        p[0] = longint'(it.px);
        p[1] = longint'(it.py);
        p[2] = longint'(it.pz);
        for (int a = 0; a < 3; a++) begin
            mn[a] = -32768; mx[a] = 32768; cmin[a] = -32768;
        end
        csize = 65536;
        node = 0;
        ncount = (node_count_reg > NODE_ENTRIES_DEF) ? NODE_ENTRIES_DEF : node_count_reg;
        scount = (sample_count_reg > SAMPLE_ENTRIES_DEF) ? SAMPLE_ENTRIES_DEF
                                                         : sample_count_reg;
        for (int c = 0; c < 8; c++)
            for (int k = 0; k < 18; k++) corner[c][k] = 8'd0;
        if (ncount != 0 && scount != 0) begin
            for (int level = 0; level < MAX_LEVELS_DEF; level++) begin
                if (node >= ncount) break;
                oct = 0;
                for (int a = 0; a < 3; a++) begin
                    mid[a] = (mn[a] + mx[a]) / 2;
                    if (p[a] >= longint'(mid[a]) * 256) oct |= (1 << a);
                end
                word = node_mem[node*8 + oct];
                if (word[15]) begin
                    all_leaf = 1'b1;
                    for (int c = 0; c < 8; c++)
                        if (!node_mem[node*8 + c][15]) all_leaf = 1'b0;
                    for (int c = 0; c < 8; c++) begin
                        w16 = all_leaf ? node_mem[node*8 + c] : word;
                        s = w16[14:0];
                        for (int k = 0; k < 18; k++)
                            corner[c][k] = (s < scount) ? sample_mem[s*18 + k] : 8'd0;
                    end
                    for (int a = 0; a < 3; a++) cmin[a] = mn[a];
                    csize = mx[0] - mn[0];
                    break;
                end
                for (int a = 0; a < 3; a++) begin
                    if (oct & (1 << a)) mn[a] = mid[a];
                    else mx[a] = mid[a];
                end
                node = word;
            end
        end
        for (int a = 0; a < 3; a++) f[a] = axis_frac(p[a], cmin[a], csize);
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            for (int col = 0; col < COLORS; col++) begin
                sum = 0;
                for (int c = 0; c < 8; c++) begin
                    wt = 1;
                    for (int a = 0; a < 3; a++)
                        wt = wt * (((c >> a) & 1) ? f[a] : 65536 - f[a]);
                    sum += longint'(corner[c][ch*3 + col]) * wt;
                end
                r = (sum + (64'd1 << 47)) >> 48;
                rgb[col] = (r > 255) ? 8'd255 : r[7:0];
            end
            res.channel = ch[2:0];
            res.red = rgb[0];
            res.green = rgb[1];
            res.blue = rgb[2];
            res.last = (ch[2:0] == LAST_CH);
            shade_q.push_back(res);
        end
    endtask

    task automatic apply_item(input req_t it);
        case (it.op)
            OP_NODE_WR: begin
                write_count++;
                if (it.idx < NODE_ENTRIES_DEF && it.slot < 8)
                    node_mem[it.idx*8 + it.slot] = it.val;
            end
            OP_SAMPLE_WR: begin
                write_count++;
                if (it.idx < SAMPLE_ENTRIES_DEF && it.slot < 18)
                    sample_mem[it.idx*18 + it.slot] = it.val[7:0];
            end
            OP_QUERY: begin
                query_count++;
                shade_point(it);
            end
            default: ;
        endcase
    endtask

    // driver
    req_t cur_req;
    int   send_gap = 0;
    bit   send_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) apply_item(cur_req);
            if (s_tvalid && !s_tready) begin
                // hold the item
            end else if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_q.size() != 0) begin
                cur_req = pending_q.pop_front();
                s_tdata <= {4'b0, cur_req.pz, cur_req.py, cur_req.px,
                            cur_req.val, cur_req.slot, cur_req.idx};
                s_tuser <= cur_req.op;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int ready_gap = 0;
    bit take_burst = 1'b0;

    task automatic report_miss(input string what, input int exp_v, input int got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
    endtask

    always @(posedge aclk) begin
        shade_t want;
        int     g;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (shade_q.size() == 0) begin
                    report_miss("unexpected result, channel", -1, m_tdata[2:0]);
                end else begin
                    want = shade_q.pop_front();
                    if (m_tdata[2:0] != want.channel)
                        report_miss("channel", want.channel, m_tdata[2:0]);
                    if (m_tdata[10:3] != want.red) report_miss("red", want.red, m_tdata[10:3]);
                    if (m_tdata[18:11] != want.green)
                        report_miss("green", want.green, m_tdata[18:11]);
                    if (m_tdata[26:19] != want.blue)
                        report_miss("blue", want.blue, m_tdata[26:19]);
                    if (m_tlast != want.last) report_miss("last", want.last, m_tlast);
                end
                if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
                g = take_burst ? 0 : $urandom_range(0, 10);
                ready_gap <= g;
                m_tready <= (g == 0);
            end else if (ready_gap != 0) begin
                ready_gap <= ready_gap - 1;
                m_tready <= (ready_gap == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus helpers
    function automatic req_t rand_req(input logic [1:0] op);
        req_t it;
        it.op = op;
        it.idx = $urandom;
        it.slot = $urandom;
        it.val = $urandom;
        it.px = $urandom;
        it.py = $urandom;
        it.pz = $urandom;
        return it;
    endfunction

    // index into the loaded range, or far out of range
    function automatic logic [14:0] pick_ref();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, LOADED - 1)
                                          : $urandom_range(4096, 32767);
    endfunction

    task automatic push_node(input int idx, input int slot, input logic [15:0] v);
        req_t it;
        it = rand_req(OP_NODE_WR);
        it.idx = idx; it.slot = slot; it.val = v;
        pending_q.push_back(it);
    endtask

    task automatic push_sample(input int idx, input int slot, input logic [15:0] v);
        req_t it;
        it = rand_req(OP_SAMPLE_WR);
        it.idx = idx; it.slot = slot; it.val = v;
        pending_q.push_back(it);
    endtask

    task automatic push_query(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
        req_t it;
        it = rand_req(OP_QUERY);
        it.px = x; it.py = y; it.pz = z;
        pending_q.push_back(it);
    endtask

    task automatic push_noise();
        req_t it;
        case ($urandom_range(0, 2))
            0: it = rand_req(OP_UNUSED);
            1: begin
                it = rand_req(OP_NODE_WR);
                if ($urandom_range(0, 1)) it.idx = $urandom_range(4096, 32767);
                else it.slot = $urandom_range(8, 31);
            end
            default: begin
                it = rand_req(OP_SAMPLE_WR);
                if ($urandom_range(0, 1)) it.idx = $urandom_range(4096, 32767);
                else it.slot = $urandom_range(18, 31);
            end
        endcase
        pending_q.push_back(it);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || shade_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_counts(input int nodes, input int samples);
        logic [31:0] junk, rd;
        junk = {$urandom_range(0, 1) ? $urandom : 32'd0};
        apb_access(1'b1, ADDR_NODES, {junk[31:13], nodes[12:0]}, rd);
        node_count_reg = nodes[12:0];
        junk = {$urandom_range(0, 1) ? $urandom : 32'd0};
        apb_access(1'b1, ADDR_SAMPLES, {junk[31:13], samples[12:0]}, rd);
        sample_count_reg = samples[12:0];
        apb_access(1'b0, ADDR_NODES, '0, rd);
        if (rd[12:0] != node_count_reg) report_miss("node_count readback", node_count_reg, rd);
        apb_access(1'b0, ADDR_SAMPLES, '0, rd);
        if (rd[12:0] != sample_count_reg)
            report_miss("sample_count readback", sample_count_reg, rd);
    endtask

    initial begin
        int phase_nodes[8];
        int phase_samples[8];
        int sel, lvl;
        phase_nodes   = '{6, 1, 8191, 4096, 0, 3, 4096, 2};
        phase_samples = '{6, 1, 8191, 0, 4096, 6, 4096, 5};
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // no map loaded, then ignored writes and the unused operation
        push_query(24'h000000, 24'h000000, 24'h000000);
        push_query(24'h800000, 24'h7fffff, 24'h800000);
        push_node(4096, 3, 16'hffff);
        push_node(0, 9, 16'h8001);
        push_sample(5000, 4, 16'hffff);
        push_sample(0, 18, 16'h00aa);
        push_sample(1, 31, 16'h00bb);
        pending_q.push_back(rand_req(OP_UNUSED));

        // load the working nodes and samples; the last node holds eight leaves
        for (int n = 0; n < LOADED; n++)
            for (int c = 0; c < CHILDREN; c++)
                push_node(n, c, (n == LOADED - 1) ? {1'b1, pick_ref()}
                                                  : {$urandom_range(0, 1) == 1, pick_ref()});
        for (int s = 0; s < LOADED; s++)
            for (int b = 0; b < SAMPLE_BYTES; b++) push_sample(s, b, $urandom);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            set_counts(phase_nodes[ph], phase_samples[ph]);
            if (ph == 0) begin
                push_query(24'h000000, 24'h000000, 24'h000000);
                push_query(24'h7fffff, 24'h7fffff, 24'h7fffff);
                push_query(24'h800000, 24'h800000, 24'h800000);
                push_query(24'hffffff, 24'h000001, 24'h400000);
            end
            for (int k = 0; k < 16; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    push_query($urandom, $urandom, $urandom);
                end else if (sel < 68) begin
                    push_node($urandom_range(0, LOADED - 1), $urandom_range(0, 7),
                              {$urandom_range(0, 1) == 1, pick_ref()});
                end else if (sel < 85) begin
                    push_sample($urandom_range(0, LOADED - 1), $urandom_range(0, 17), $urandom);
                end else if (sel < 92) begin
                    // rewrite a node as all leaves, then send a random query
                    lvl = $urandom_range(0, LOADED - 1);
                    for (int c = 0; c < CHILDREN; c++) push_node(lvl, c, {1'b1, pick_ref()});
                    push_query($urandom, $urandom, $urandom);
                end else begin
                    push_noise();
                end
            end
            wait_drained();
        end

        $display("%0d queries and %0d writes sent, %0d results checked, 8 count settings",
                 query_count, write_count, result_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
